[rtl/obb_pkg.sv]
// Shared types for the oriented-box overlap unit: datapath ops, operand codes, command/status.
`default_nettype none
package obb_pkg;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_SQRT,
		OP_DIV,
		OP_AXIS,
		OP_CROSS,
		OP_PROJ,
		OP_LENA,
		OP_CHECK,
		OP_LOADREF,
		OP_DONE
	} op_t;

	// multiplier operand sources
	typedef enum logic [4:0] {
		SRC_MRX, SRC_MRY, SRC_MUX, SRC_MUY,
		SRC_ARX, SRC_ARY, SRC_AUX, SRC_AUY,
		SRC_TRX, SRC_TRY, SRC_TUX, SRC_TUY,
		SRC_DX, SRC_DY,
		SRC_CR0, SRC_CR1, SRC_CR2, SRC_CR3,
		SRC_HW, SRC_HH, SRC_RHW, SRC_RHH
	} src_t;

	typedef struct packed {
		logic       latch;
		op_t        op;
		logic [1:0] idx;
		logic       mul_en;
		src_t       a_sel;
		src_t       b_sel;
		logic       acc_en;
		logic       acc_clr;
	} dp_cmd_t;

	typedef struct packed {
		logic busy;
		logic is_test;
	} dp_stat_t;

endpackage
`default_nettype wire

[rtl/obb_rootdiv.sv]
// Shared iterative unit: bit-serial integer square root and restoring divide by that root.
`default_nettype none
module obb_rootdiv #(
	parameter int RAD_W = 64,
	parameter int NUM_W = 48
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start_sqrt,
	input  logic                   start_div,
	input  logic [RAD_W-1:0]       radicand,
	input  logic [NUM_W-1:0]       dividend,
	output logic                   busy,
	output logic [RAD_W/2-1:0]     root,
	output logic [NUM_W-1:0]       quo
);
	localparam int ROOT_W = RAD_W / 2;
	localparam int MAXI   = (NUM_W > ROOT_W) ? NUM_W : ROOT_W;
	localparam int CNT_W  = $clog2(MAXI + 1);

	logic              busy_q;
	logic              div_mode_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [RAD_W-1:0]  rad_q;
	logic [ROOT_W:0]   srem_q;
	logic [ROOT_W-1:0] root_q;
	logic [NUM_W-1:0]  num_q;
	logic [ROOT_W-1:0] drem_q;

	logic [ROOT_W+2:0] s_try, s_trial, s_diff;
	logic              s_ge;
	logic [ROOT_W:0]   d_try, d_diff;
	logic              d_ge;

	// two radicand bits per step
	assign s_try   = {srem_q, rad_q[RAD_W-1 -: 2]};
	assign s_trial = {1'b0, root_q, 2'b01};
	assign s_ge    = (s_try >= s_trial);
	assign s_diff  = s_try - s_trial;

	// one quotient bit per step, divisor is the last root
	assign d_try  = {drem_q, num_q[NUM_W-1]};
	assign d_ge   = (d_try >= {1'b0, root_q});
	assign d_diff = d_try - {1'b0, root_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q     <= 1'b0;
			div_mode_q <= 1'b0;
			cnt_q      <= '0;
		end else if (start_sqrt) begin
			busy_q     <= 1'b1;
			div_mode_q <= 1'b0;
			cnt_q      <= CNT_W'(ROOT_W);
		end else if (start_div) begin
			busy_q     <= 1'b1;
			div_mode_q <= 1'b1;
			cnt_q      <= CNT_W'(NUM_W);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CNT_W'(1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start_sqrt) begin
			rad_q  <= radicand;
			srem_q <= '0;
			root_q <= '0;
		end else if (start_div) begin
			num_q  <= dividend;
			drem_q <= '0;
		end else if (busy_q) begin
			if (!div_mode_q) begin
				srem_q <= s_ge ? s_diff[ROOT_W:0] : s_try[ROOT_W:0];
				root_q <= {root_q[ROOT_W-2:0], s_ge};
				rad_q  <= {rad_q[RAD_W-3:0], 2'b00};
			end else begin
				drem_q <= d_ge ? d_diff[ROOT_W-1:0] : d_try[ROOT_W-1:0];
				num_q  <= {num_q[NUM_W-2:0], d_ge};
			end
		end
	end

	assign busy = busy_q;
	assign root = root_q;
	assign quo  = num_q;

endmodule
`default_nettype wire

[rtl/obb_dp.sv]
// Datapath: request registers, reference box, shared multiplier and accumulator, axis tests.
`default_nettype none
module obb_dp import obb_pkg::*; #(
	parameter int FRAC_BITS   = 16,
	parameter int COORD_WIDTH = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  dp_cmd_t                       dcmd,
	output dp_stat_t                      stat,
	input  logic                          cmd,
	input  logic signed [COORD_WIDTH-1:0] center_x,
	input  logic signed [COORD_WIDTH-1:0] center_y,
	input  logic signed [COORD_WIDTH-1:0] right_x,
	input  logic signed [COORD_WIDTH-1:0] right_y,
	input  logic signed [COORD_WIDTH-1:0] up_x,
	input  logic signed [COORD_WIDTH-1:0] up_y,
	input  logic [COORD_WIDTH-2:0]        half_width,
	input  logic [COORD_WIDTH-2:0]        half_height,
	output logic                          overlap
);
	localparam int CW  = COORD_WIDTH;
	localparam int F   = FRAC_BITS;
	localparam int OW  = (CW + 1 > F + 3) ? CW + 1 : F + 3;
	localparam int AW  = 2 * OW + 2;
	localparam int SQW = (2 * CW > 64) ? 64 : 2 * CW;
	localparam int RTW = SQW / 2;
	localparam int NW  = CW + F;
	localparam int AXW = F + 2;
	localparam logic [NW-1:0] ONE_N = {{(NW-F-1){1'b0}}, 1'b1, {F{1'b0}}};

	logic                  is_test_q;
	logic signed [CW-1:0]  cx_q, cy_q;
	logic [CW-1:0]         mag_q [4];
	logic [3:0]            neg_q;
	logic [CW-2:0]         hw_q, hh_q;
	logic signed [CW:0]    dx_q, dy_q;
	logic signed [AXW-1:0] tax_q [4];
	logic [AXW-1:0]        cr_q [4];
	logic [AW-1:0]         pj_q [4];
	logic signed [2*OW-1:0] prod_q;
	logic signed [AW-1:0]  acc_q;
	logic                  ok_q;
	logic                  overlap_q;

	logic signed [CW-1:0]  ref_cx_q, ref_cy_q;
	logic signed [AXW-1:0] rax_q [4];
	logic [CW-2:0]         rhw_q, rhh_q;

	logic                  ud_busy;
	logic [RTW-1:0]        ud_root;
	logic [NW-1:0]         ud_quo;

	logic signed [OW-1:0]  op_a, op_b;
	logic [AW-1:0]         lena, absacc;
	logic [NW-1:0]         qcl;
	logic [AXW-1:0]        qmag;
	logic signed [AXW-1:0] ax_new;

	function automatic logic [CW-1:0] mag(input logic signed [CW-1:0] v);
		return v[CW-1] ? CW'(-v) : CW'(v);
	endfunction

	function automatic logic signed [OW-1:0] src_val(input src_t s);
		case (s)
			SRC_MRX: return OW'(mag_q[0]);
			SRC_MRY: return OW'(mag_q[1]);
			SRC_MUX: return OW'(mag_q[2]);
			SRC_MUY: return OW'(mag_q[3]);
			SRC_ARX: return OW'(rax_q[0]);
			SRC_ARY: return OW'(rax_q[1]);
			SRC_AUX: return OW'(rax_q[2]);
			SRC_AUY: return OW'(rax_q[3]);
			SRC_TRX: return OW'(tax_q[0]);
			SRC_TRY: return OW'(tax_q[1]);
			SRC_TUX: return OW'(tax_q[2]);
			SRC_TUY: return OW'(tax_q[3]);
			SRC_DX:  return OW'(dx_q);
			SRC_DY:  return OW'(dy_q);
			SRC_CR0: return OW'(cr_q[0]);
			SRC_CR1: return OW'(cr_q[1]);
			SRC_CR2: return OW'(cr_q[2]);
			SRC_CR3: return OW'(cr_q[3]);
			SRC_HW:  return OW'(hw_q);
			SRC_HH:  return OW'(hh_q);
			SRC_RHW: return OW'(rhw_q);
			SRC_RHH: return OW'(rhh_q);
			default: return '0;
		endcase
	endfunction

	always_comb begin
		op_a = src_val(dcmd.a_sel);
		op_b = src_val(dcmd.b_sel);
	end

	// own-axis half extent, zero when the axis is the zero vector
	always_comb begin
		case (dcmd.idx)
			2'd0: lena = (rax_q[0] != '0 || rax_q[1] != '0) ?
				AW'({rhw_q, {F{1'b0}}}) : '0;
			2'd1: lena = (rax_q[2] != '0 || rax_q[3] != '0) ?
				AW'({rhh_q, {F{1'b0}}}) : '0;
			2'd2: lena = (tax_q[0] != '0 || tax_q[1] != '0) ?
				AW'({hw_q, {F{1'b0}}}) : '0;
			default: lena = (tax_q[2] != '0 || tax_q[3] != '0) ?
				AW'({hh_q, {F{1'b0}}}) : '0;
		endcase
	end

	assign absacc = acc_q[AW-1] ? AW'(-acc_q) : AW'(acc_q);

	// quotient clamped to 1.0, signed back, zero vector gives zero
	always_comb begin
		qcl    = (ud_quo > ONE_N) ? ONE_N : ud_quo;
		qmag   = qcl[AXW-1:0];
		ax_new = (ud_root == '0) ? '0 :
			(neg_q[dcmd.idx] ? -$signed(qmag) : $signed(qmag));
	end

	obb_rootdiv #(
		.RAD_W (SQW),
		.NUM_W (NW)
	) u_rootdiv (
		.clk        (clk),
		.arst_n     (arst_n),
		.start_sqrt (dcmd.op == OP_SQRT),
		.start_div  (dcmd.op == OP_DIV),
		.radicand   (acc_q[SQW-1:0]),
		.dividend   ({mag_q[dcmd.idx], {F{1'b0}}}),
		.busy       (ud_busy),
		.root       (ud_root),
		.quo        (ud_quo)
	);

	always_ff @(posedge clk) begin
		if (dcmd.latch) begin
			is_test_q <= cmd;
			cx_q      <= center_x;
			cy_q      <= center_y;
			mag_q[0]  <= mag(right_x);
			mag_q[1]  <= mag(right_y);
			mag_q[2]  <= mag(up_x);
			mag_q[3]  <= mag(up_y);
			neg_q     <= {up_y[CW-1], up_x[CW-1], right_y[CW-1], right_x[CW-1]};
			hw_q      <= half_width;
			hh_q      <= half_height;
			dx_q      <= (CW+1)'(ref_cx_q) - (CW+1)'(center_x);
			dy_q      <= (CW+1)'(ref_cy_q) - (CW+1)'(center_y);
			ok_q      <= 1'b1;
		end
		if (dcmd.mul_en) begin
			prod_q <= op_a * op_b;
		end
		if (dcmd.op == OP_LENA) begin
			acc_q <= $signed(lena);
		end else if (dcmd.acc_en) begin
			acc_q <= (dcmd.acc_clr ? '0 : acc_q) + AW'(prod_q);
		end
		case (dcmd.op)
			OP_AXIS:  tax_q[dcmd.idx] <= ax_new;
			OP_CROSS: cr_q[dcmd.idx]  <= absacc[F+AXW-1:F];
			OP_PROJ:  pj_q[dcmd.idx]  <= absacc;
			OP_CHECK: begin
				if (pj_q[dcmd.idx] > $unsigned(acc_q)) begin
					ok_q <= 1'b0;
				end
			end
			OP_DONE:  overlap_q <= ok_q;
			default: ;
		endcase
	end

	// reference box
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ref_cx_q <= '0;
			ref_cy_q <= '0;
			rax_q[0] <= '0;
			rax_q[1] <= '0;
			rax_q[2] <= '0;
			rax_q[3] <= '0;
			rhw_q    <= '0;
			rhh_q    <= '0;
		end else if (dcmd.op == OP_LOADREF && !is_test_q) begin
			ref_cx_q <= cx_q;
			ref_cy_q <= cy_q;
			rax_q[0] <= tax_q[0];
			rax_q[1] <= tax_q[1];
			rax_q[2] <= tax_q[2];
			rax_q[3] <= tax_q[3];
			rhw_q    <= hw_q;
			rhh_q    <= hh_q;
		end
	end

	assign stat.busy    = ud_busy;
	assign stat.is_test = is_test_q;
	assign overlap      = overlap_q;

endmodule
`default_nettype wire

[rtl/obb_ctrl.sv]
// Controller: sequencer FSM stepping a fixed micro-program and owning both handshakes.
`default_nettype none
module obb_ctrl import obb_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	output logic     out_valid,
	input  logic     out_ready,
	input  dp_stat_t stat,
	output dp_cmd_t  dcmd
);
	localparam int PCW = 7;
	localparam logic [PCW-1:0] PC_LOAD = 7'd16;
	localparam logic [PCW-1:0] PC_DOT  = 7'd17;
	localparam logic [PCW-1:0] PC_AXIS = 7'd49;
	localparam logic [PCW-1:0] PC_DONE = 7'd65;
	localparam dp_cmd_t CMD_NOP = '{latch: 1'b0, op: OP_NONE, idx: 2'd0, mul_en: 1'b0,
		a_sel: SRC_MRX, b_sel: SRC_MRX, acc_en: 1'b0, acc_clr: 1'b0};

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_RUN  = 3'b010,
		S_WAIT = 3'b100
	} state_t;

	state_t         state_q, state_d;
	logic [PCW-1:0] pc_q, pc_d;
	logic           out_valid_q, out_set;

	function automatic dp_cmd_t micro(input logic [PCW-1:0] pc);
		dp_cmd_t        c;
		logic [PCW-1:0] q;
		logic           v;
		logic [2:0]     p;
		logic [1:0]     s;
		src_t           a0, b0, a1, b1;
		c  = CMD_NOP;
		q  = '0;
		v  = pc[3];
		p  = '0;
		s  = '0;
		a0 = SRC_MRX;
		b0 = SRC_MRX;
		a1 = SRC_MRX;
		b1 = SRC_MRX;
		if (pc < PC_LOAD) begin
			// normalize right axis, then up axis
			case (pc[2:0])
				3'd0: begin
					c.mul_en = 1'b1;
					c.a_sel  = v ? SRC_MUX : SRC_MRX;
					c.b_sel  = c.a_sel;
				end
				3'd1: begin
					c.acc_en  = 1'b1;
					c.acc_clr = 1'b1;
					c.mul_en  = 1'b1;
					c.a_sel   = v ? SRC_MUY : SRC_MRY;
					c.b_sel   = c.a_sel;
				end
				3'd2: c.acc_en = 1'b1;
				3'd3: c.op = OP_SQRT;
				3'd4: begin c.op = OP_DIV;  c.idx = {v, 1'b0}; end
				3'd5: begin c.op = OP_AXIS; c.idx = {v, 1'b0}; end
				3'd6: begin c.op = OP_DIV;  c.idx = {v, 1'b1}; end
				default: begin c.op = OP_AXIS; c.idx = {v, 1'b1}; end
			endcase
		end else if (pc == PC_LOAD) begin
			c.op = OP_LOADREF;
		end else if (pc < PC_AXIS) begin
			// four cross dots of unit axes, then four center-offset dots
			q = pc - PC_DOT;
			p = q[4:2];
			s = q[1:0];
			case (p)
				3'd0: begin a0 = SRC_ARX; b0 = SRC_TRX; a1 = SRC_ARY; b1 = SRC_TRY; end
				3'd1: begin a0 = SRC_ARX; b0 = SRC_TUX; a1 = SRC_ARY; b1 = SRC_TUY; end
				3'd2: begin a0 = SRC_AUX; b0 = SRC_TRX; a1 = SRC_AUY; b1 = SRC_TRY; end
				3'd3: begin a0 = SRC_AUX; b0 = SRC_TUX; a1 = SRC_AUY; b1 = SRC_TUY; end
				3'd4: begin a0 = SRC_ARX; b0 = SRC_DX;  a1 = SRC_ARY; b1 = SRC_DY;  end
				3'd5: begin a0 = SRC_AUX; b0 = SRC_DX;  a1 = SRC_AUY; b1 = SRC_DY;  end
				3'd6: begin a0 = SRC_TRX; b0 = SRC_DX;  a1 = SRC_TRY; b1 = SRC_DY;  end
				default: begin a0 = SRC_TUX; b0 = SRC_DX; a1 = SRC_TUY; b1 = SRC_DY; end
			endcase
			case (s)
				2'd0: begin c.mul_en = 1'b1; c.a_sel = a0; c.b_sel = b0; end
				2'd1: begin
					c.mul_en  = 1'b1;
					c.a_sel   = a1;
					c.b_sel   = b1;
					c.acc_en  = 1'b1;
					c.acc_clr = 1'b1;
				end
				2'd2: c.acc_en = 1'b1;
				default: begin
					c.op  = p[2] ? OP_PROJ : OP_CROSS;
					c.idx = p[1:0];
				end
			endcase
		end else if (pc < PC_DONE) begin
			// per axis: own extent + two projected extents, then compare
			q = pc - PC_AXIS;
			s = q[1:0];
			case (q[3:2])
				2'd0: begin a0 = SRC_CR0; b0 = SRC_HW;  a1 = SRC_CR1; b1 = SRC_HH;  end
				2'd1: begin a0 = SRC_CR2; b0 = SRC_HW;  a1 = SRC_CR3; b1 = SRC_HH;  end
				2'd2: begin a0 = SRC_CR0; b0 = SRC_RHW; a1 = SRC_CR2; b1 = SRC_RHH; end
				default: begin a0 = SRC_CR1; b0 = SRC_RHW; a1 = SRC_CR3; b1 = SRC_RHH; end
			endcase
			c.idx = q[3:2];
			case (s)
				2'd0: begin c.op = OP_LENA; c.mul_en = 1'b1; c.a_sel = a0; c.b_sel = b0; end
				2'd1: begin c.acc_en = 1'b1; c.mul_en = 1'b1; c.a_sel = a1; c.b_sel = b1; end
				2'd2: c.acc_en = 1'b1;
				default: c.op = OP_CHECK;
			endcase
		end else begin
			c.op = OP_DONE;
		end
		return c;
	endfunction

	always_comb begin
		state_d  = state_q;
		pc_d     = pc_q;
		out_set  = 1'b0;
		in_ready = 1'b0;
		dcmd     = CMD_NOP;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					dcmd.latch = 1'b1;
					pc_d       = '0;
					state_d    = S_RUN;
				end
			end
			S_RUN: begin
				dcmd = micro(pc_q);
				if (dcmd.op == OP_SQRT || dcmd.op == OP_DIV) begin
					pc_d    = pc_q + 1'b1;
					state_d = S_WAIT;
				end else if (dcmd.op == OP_LOADREF && !stat.is_test) begin
					state_d = S_IDLE;
				end else if (dcmd.op == OP_DONE) begin
					if (!out_valid_q || out_ready) begin
						out_set = 1'b1;
						state_d = S_IDLE;
					end else begin
						dcmd.op = OP_NONE;
					end
				end else begin
					pc_d = pc_q + 1'b1;
				end
			end
			S_WAIT: begin
				if (!stat.busy) begin
					state_d = S_RUN;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			pc_q        <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			pc_q    <= pc_d;
			if (out_set) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

endmodule
`default_nettype wire

[rtl/obb_overlap_test_2d_unit.sv]
// Top level: 2D oriented-box overlap test (separating axis theorem), Q16.16 fixed point.
// Throughput: one request at a time; the iterative root/divide unit (one result bit per cycle)
//   sets the pace. A result waits in the output register while the next request enters.
// Reset: arst_n clears the sequencer, the output valid and the reference box (origin, zero axes).
`default_nettype none
module obb_overlap_test_2d_unit import obb_pkg::*; #(
	parameter int FRAC_BITS   = 16,
	parameter int COORD_WIDTH = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic                          cmd,
	input  logic signed [COORD_WIDTH-1:0] center_x,
	input  logic signed [COORD_WIDTH-1:0] center_y,
	input  logic signed [COORD_WIDTH-1:0] right_x,
	input  logic signed [COORD_WIDTH-1:0] right_y,
	input  logic signed [COORD_WIDTH-1:0] up_x,
	input  logic signed [COORD_WIDTH-1:0] up_y,
	input  logic [COORD_WIDTH-2:0]        half_width,
	input  logic [COORD_WIDTH-2:0]        half_height,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic                          overlap
);
	// Flow per request: latch the fields, normalize the right and up axes (sum of
	// squares on the shared multiplier, integer root, two divides), then either
	// copy the box into the reference (load) or run the four-axis test.
	// The test takes 8 dot products (4 axis-vs-axis, 4 axis-vs-offset) and per
	// axis compares |axis . d| against own extent + two projected extents.
	// Equality counts as overlap.

	dp_cmd_t  dcmd;
	dp_stat_t stat;

	obb_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.stat      (stat),
		.dcmd      (dcmd)
	);

	obb_dp #(
		.FRAC_BITS   (FRAC_BITS),
		.COORD_WIDTH (COORD_WIDTH)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.dcmd        (dcmd),
		.stat        (stat),
		.cmd         (cmd),
		.center_x    (center_x),
		.center_y    (center_y),
		.right_x     (right_x),
		.right_y     (right_y),
		.up_x        (up_x),
		.up_y        (up_y),
		.half_width  (half_width),
		.half_height (half_height),
		.overlap     (overlap)
	);

endmodule
`default_nettype wire

[rtl/obb_chk.sv]
// Port-level checker for the overlap unit, bound to the top level.
`default_nettype none
module obb_chk (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready,
	input logic overlap
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(overlap))
		else $error("result dropped or changed while stalled");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("request taken while another is in work");

	a_idle_holds: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready && !in_valid |=> in_ready)
		else $error("idle unit went busy without a request");

	a_result_ends_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> in_ready && !$past(in_ready))
		else $error("result appeared outside the end of a test");

endmodule

bind obb_overlap_test_2d_unit obb_chk u_obb_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.overlap   (overlap)
);
`default_nettype wire

[tb/sv/tb_obb_overlap_test_2d_unit.sv]
// Testbench for obb_overlap_test_2d_unit: random and directed box requests checked by a predictor.
`default_nettype none
module tb_obb_overlap_test_2d_unit;
	import obb_pkg::*;

	localparam int FRAC_BITS   = 16;
	localparam int COORD_WIDTH = 32;
	localparam int N_RANDOM    = 1200;
	localparam longint CYCLE_LIMIT = 4000000;
	localparam int LONG_HOLD   = 3000;

	localparam bit CMD_LOAD = 1'b0;
	localparam bit CMD_TEST = 1'b1;

	typedef struct {
		bit                    cmd;
		bit [COORD_WIDTH-1:0]  cx, cy, rx, ry, ux, uy;
		bit [COORD_WIDTH-2:0]  hw, hh;
	} box_req_t;

	// Holds the reference box and the queue of expected overlap flags.
	class overlap_scoreboard;
		bit [63:0] ref_cx, ref_cy, ref_rx, ref_ry, ref_ux, ref_uy, ref_hw, ref_hh;
		bit        overlap_q[$];
		int        errors;

		function bit [63:0] sext(bit [COORD_WIDTH-1:0] v);
			return {{(64-COORD_WIDTH){v[COORD_WIDTH-1]}}, v};
		endfunction

		function bit [63:0] mag(bit [63:0] v);
			return v[63] ? 64'd0 - v : v;
		endfunction

		function bit [63:0] int_sqrt(bit [63:0] n);
			bit [63:0] r, b;
			r = 0;
			b = 64'd1 << 62;
			while (b > n) b = b >> 2;
			while (b != 0) begin
				if (n >= r + b) begin
					n = n - (r + b);
					r = (r >> 1) + b;
				end else begin
					r = r >> 1;
				end
				b = b >> 2;
			end
			return r;
		endfunction

		// unit vector in Q.FRAC_BITS; zero vector stays zero
		function void unit_vec(bit [63:0] x, bit [63:0] y, output bit [63:0] nx,
				output bit [63:0] ny);
			bit [63:0] ax, ay, len, qx, qy, one;
			ax = mag(x);
			ay = mag(y);
			one = 64'd1 << FRAC_BITS;
			if (ax * ax + ay * ay == 0) begin
				nx = 0;
				ny = 0;
				return;
			end
			len = int_sqrt(ax * ax + ay * ay);
			qx = (ax << FRAC_BITS) / len;
			qy = (ay << FRAC_BITS) / len;
			if (qx > one) qx = one;
			if (qy > one) qy = one;
			nx = x[63] ? 64'd0 - qx : qx;
			ny = y[63] ? 64'd0 - qy : qy;
		endfunction

		function bit [63:0] abs_dot(bit [63:0] ax, bit [63:0] ay, bit [63:0] bx, bit [63:0] by);
			return mag(ax * bx + ay * by);
		endfunction

		// no separation along axis p
		function bit axis_holds(bit [63:0] px, bit [63:0] py, bit [63:0] hown,
				bit [63:0] e1x, bit [63:0] e1y, bit [63:0] h1,
				bit [63:0] e2x, bit [63:0] e2y, bit [63:0] h2,
				bit [63:0] dx, bit [63:0] dy);
			bit [63:0] span, sep;
			span = (px != 0 || py != 0) ? (hown << FRAC_BITS) : 64'd0;
			sep = (abs_dot(px, py, e1x, e1y) >> FRAC_BITS) * h1
				+ (abs_dot(px, py, e2x, e2y) >> FRAC_BITS) * h2;
			return abs_dot(px, py, dx, dy) <= span + sep;
		endfunction

		function void note_request(box_req_t b);
			bit [63:0] rx, ry, ux, uy, dx, dy, hw, hh;
			bit ok;
			unit_vec(sext(b.rx), sext(b.ry), rx, ry);
			unit_vec(sext(b.ux), sext(b.uy), ux, uy);
			hw = {33'd0, b.hw};
			hh = {33'd0, b.hh};
			if (b.cmd == CMD_LOAD) begin
				ref_cx = sext(b.cx); ref_cy = sext(b.cy);
				ref_rx = rx; ref_ry = ry; ref_ux = ux; ref_uy = uy;
				ref_hw = hw; ref_hh = hh;
				return;
			end
			dx = ref_cx - sext(b.cx);
			dy = ref_cy - sext(b.cy);
			ok = axis_holds(ref_rx, ref_ry, ref_hw, rx, ry, hw, ux, uy, hh, dx, dy)
				&& axis_holds(ref_ux, ref_uy, ref_hh, rx, ry, hw, ux, uy, hh, dx, dy)
				&& axis_holds(rx, ry, hw, ref_rx, ref_ry, ref_hw, ref_ux, ref_uy, ref_hh, dx, dy)
				&& axis_holds(ux, uy, hh, ref_rx, ref_ry, ref_hw, ref_ux, ref_uy, ref_hh, dx, dy);
			overlap_q.push_back(ok);
		endfunction

		function void check_result(bit got);
			bit want;
			if (overlap_q.size() == 0) begin
				errors++;
				if (errors <= 10) $display("unexpected result: overlap=%0b", got);
				return;
			end
			want = overlap_q.pop_front();
			if (got !== want) begin
				errors++;
				if (errors <= 10) $display("overlap mismatch: expected %0b, got %0b", want, got);
			end
		endfunction
	endclass

	logic                          clk = 1'b0;
	logic                          arst_n = 1'b0;
	logic                          in_valid = 1'b0;
	logic                          in_ready;
	logic                          cmd = 1'b0;
	logic signed [COORD_WIDTH-1:0] center_x = '0, center_y = '0;
	logic signed [COORD_WIDTH-1:0] right_x = '0, right_y = '0, up_x = '0, up_y = '0;
	logic [COORD_WIDTH-2:0]        half_width = '0, half_height = '0;
	logic                          out_valid;
	logic                          out_ready = 1'b0;
	logic                          overlap;

	overlap_scoreboard sb = new();
	longint cycles = 0;
	bit     hold_request = 1'b0;   // asks the receiver for one long hold-off

	obb_overlap_test_2d_unit #(.FRAC_BITS(FRAC_BITS), .COORD_WIDTH(COORD_WIDTH)) DUT (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.cmd(cmd), .center_x(center_x), .center_y(center_y),
		.right_x(right_x), .right_y(right_y), .up_x(up_x), .up_y(up_y),
		.half_width(half_width), .half_height(half_height),
		.out_valid(out_valid), .out_ready(out_ready), .overlap(overlap)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Handshake monitor: values read here are the ones before this edge's updates.
	always @(posedge clk) begin
		box_req_t b;
		cycles <= cycles + 1;
		if (arst_n && in_valid && in_ready) begin
			b.cmd = cmd;
			b.cx = center_x; b.cy = center_y;
			b.rx = right_x; b.ry = right_y; b.ux = up_x; b.uy = up_y;
			b.hw = half_width; b.hh = half_height;
			sb.note_request(b);
		end
		if (arst_n && out_valid && out_ready) sb.check_result(overlap);
		if (cycles > CYCLE_LIMIT) begin
			$display("tb_obb_overlap_test_2d_unit: FAIL");
			$finish;
		end
	end

	function int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 65) return 0;
		if (r < 95) return $urandom_range(1, 4);
		return $urandom_range(20, 200);
	endfunction

	// Receiver: random stalls, stretches of full readiness, and one long hold-off on request.
	initial begin
		int hold_left, stretch, calm;
		hold_left = 0;
		stretch = 0;
		calm = 0;
		forever begin
			@(posedge clk);
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else if (hold_request) begin
				hold_request = 1'b0;
				hold_left = LONG_HOLD;
				out_ready <= 1'b0;
			end else begin
				if (stretch == 0) begin
					stretch = $urandom_range(50, 400);
					calm = ($urandom_range(0, 2) == 0);
				end
				stretch--;
				if (calm) out_ready <= 1'b1;
				else if ($urandom_range(0, 99) < 4) begin
					out_ready <= 1'b0;
					hold_left = pick_gap();
				end else out_ready <= ($urandom_range(0, 3) != 0);
			end
		end
	end

	// Drive one request and return at the edge where it is taken.
	task automatic send_box(box_req_t b);
		cmd <= b.cmd;
		center_x <= b.cx; center_y <= b.cy;
		right_x <= b.rx; right_y <= b.ry; up_x <= b.ux; up_y <= b.uy;
		half_width <= b.hw; half_height <= b.hh;
		in_valid <= 1'b1;
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic send_idle(box_req_t b);
		int gap;
		send_box(b);
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	function automatic box_req_t make_box(bit c, int cx, int cy, int rx, int ry, int ux, int uy,
			int unsigned hw, int unsigned hh);
		box_req_t b;
		b.cmd = c;
		b.cx = cx; b.cy = cy; b.rx = rx; b.ry = ry; b.ux = ux; b.uy = uy;
		b.hw = hw[COORD_WIDTH-2:0]; b.hh = hh[COORD_WIDTH-2:0];
		return b;
	endfunction

	// Mostly nearby, roughly perpendicular boxes so both outcomes are common;
	// one in ten is raw noise over the whole field ranges.
	function automatic box_req_t random_box(bit c);
		box_req_t b;
		int ax, ay, k;
		b.cmd = c;
		if ($urandom_range(0, 9) == 0) begin
			b.cx = $urandom; b.cy = $urandom; b.rx = $urandom; b.ry = $urandom;
			b.ux = $urandom; b.uy = $urandom;
			b.hw = (COORD_WIDTH-1)'($urandom);
			b.hh = (COORD_WIDTH-1)'($urandom);
			return b;
		end
		b.cx = $urandom_range(0, 1 << 23) - (1 << 22);
		b.cy = $urandom_range(0, 1 << 23) - (1 << 22);
		ax = $urandom_range(0, 1 << 19) - (1 << 18);
		ay = $urandom_range(0, 1 << 19) - (1 << 18);
		k = $urandom_range(1, 4);
		b.rx = ax; b.ry = ay;
		b.ux = -ay * k; b.uy = ax * k;
		if ($urandom_range(0, 19) == 0) begin
			b.rx = 0; b.ry = 0;
		end
		if ($urandom_range(0, 19) == 0) begin
			b.ux = 0; b.uy = 0;
		end
		b.hw = (COORD_WIDTH-1)'($urandom_range(0, 1 << 22));
		b.hh = (COORD_WIDTH-1)'($urandom_range(0, 1 << 22));
		return b;
	endfunction

	initial begin
		box_req_t dir[$];
		int sent, burst;
		localparam int ONE = 1 << FRAC_BITS;
		localparam int MAXI = 32'h7fffffff;
		localparam int MINI = 32'h80000000;

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// test against the reset box (origin point, zero axes)
		dir.push_back(make_box(CMD_TEST, 3 * ONE, 0, ONE, 0, 0, ONE, ONE, ONE));
		dir.push_back(make_box(CMD_TEST, 0, 0, 0, 0, 0, 0, 0, 0));
		// unit square reference; touching edge counts as overlap, one step more separates
		dir.push_back(make_box(CMD_LOAD, 0, 0, ONE, 0, 0, ONE, ONE, ONE));
		dir.push_back(make_box(CMD_TEST, 2 * ONE, 0, ONE, 0, 0, ONE, ONE, ONE));
		dir.push_back(make_box(CMD_TEST, 2 * ONE + 1, 0, ONE, 0, 0, ONE, ONE, ONE));
		dir.push_back(make_box(CMD_TEST, 0, -2 * ONE - 1, 5 * ONE, 0, 0, 7, ONE, ONE));
		// rotated by 45 degrees, overlapping and clear
		dir.push_back(make_box(CMD_TEST, ONE, ONE, ONE, ONE, -ONE, ONE, ONE, ONE));
		dir.push_back(make_box(CMD_TEST, 3 * ONE, 3 * ONE, ONE, -ONE, ONE, ONE, ONE, ONE));
		// reference with zero axes
		dir.push_back(make_box(CMD_LOAD, ONE, -ONE, 0, 0, 0, 0, MAXI, MAXI));
		dir.push_back(make_box(CMD_TEST, 9 * ONE, 0, ONE, 0, 0, ONE, ONE, ONE));
		dir.push_back(make_box(CMD_TEST, ONE, -ONE, 0, 0, ONE, 0, 0, 0));
		// field extremes
		dir.push_back(make_box(CMD_LOAD, MINI, MAXI, MAXI, MAXI, MINI, MINI, MAXI, 0));
		dir.push_back(make_box(CMD_TEST, MAXI, MINI, MINI, MAXI, MAXI, MINI, 0, MAXI));
		dir.push_back(make_box(CMD_TEST, MINI, MINI, MINI, 0, 0, MINI, MAXI, MAXI));
		dir.push_back(make_box(CMD_TEST, -1, -1, -1, -1, -1, -1, MAXI, MAXI));
		dir.push_back(make_box(CMD_LOAD, MAXI, MAXI, -1, 0, 0, 1, 1, 1));
		dir.push_back(make_box(CMD_TEST, MAXI, MAXI, 1, 1, -1, 1, 0, 0));
		dir.push_back(make_box(CMD_TEST, 0, 0, MAXI, 1, 1, MAXI, MAXI, MAXI));
		foreach (dir[i]) send_idle(dir[i]);

		sent = 0;
		while (sent < N_RANDOM) begin
			// a group, mostly well-formed: usually a reference then a few tests against it
			send_idle(random_box($urandom_range(0, 9) == 0 ? CMD_TEST : CMD_LOAD));
			burst = $urandom_range(1, 6);
			sent++;
			repeat (burst) begin
				send_idle(random_box($urandom_range(0, 14) == 0 ? CMD_LOAD : CMD_TEST));
				sent++;
			end
			if (sent >= 300 && sent < 308) hold_request = 1'b1;
			if (sent >= 700 && sent < 708) begin
				// drain fully before going on
				in_valid <= 1'b0;
				do @(posedge clk); while (sb.overlap_q.size() != 0);
			end
		end
		in_valid <= 1'b0;

		while (sb.overlap_q.size() != 0) @(posedge clk);
		repeat (800) @(posedge clk);
		if (sb.errors == 0 && sb.overlap_q.size() == 0)
			$display("tb_obb_overlap_test_2d_unit: PASS");
		else
			$display("tb_obb_overlap_test_2d_unit: FAIL");
		$finish;
	end

endmodule
`default_nettype wire

[sim.f]
rtl/obb_pkg.sv
rtl/obb_rootdiv.sv
rtl/obb_dp.sv
rtl/obb_ctrl.sv
rtl/obb_overlap_test_2d_unit.sv
rtl/obb_chk.sv
tb/sv/tb_obb_overlap_test_2d_unit.sv
